// ===== design/sobq_pkg.sv =====
// Package: widths, coefficient and history types, register indexes for the biquad.
package sobq_pkg;

	localparam int SAMPLE_BITS    = 16;
	localparam int COEF_FRAC_BITS = 16;
	localparam int COEF_W         = COEF_FRAC_BITS + 4;
	// x + 2*x1 + x2 needs two bits of growth plus sign margin
	localparam int XS_W           = SAMPLE_BITS + 3;
	localparam int PFF_W          = COEF_W + XS_W;
	localparam int PFB_W          = COEF_W + SAMPLE_BITS;
	localparam int ACC_W          = PFF_W + 1;
	localparam int SHR_W          = ACC_W - COEF_FRAC_BITS;
	localparam int REG_IDX_W      = 2;

	localparam logic [REG_IDX_W-1:0] REG_GAIN_B0     = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_FEEDBACK_A1 = REG_IDX_W'(1);
	localparam logic [REG_IDX_W-1:0] REG_FEEDBACK_A2 = REG_IDX_W'(2);
	localparam logic [REG_IDX_W-1:0] REG_BYPASS_MODE = REG_IDX_W'(3);

	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);

	typedef struct packed {
		logic signed [COEF_W-1:0] b0;
		logic signed [COEF_W-1:0] a1;
		logic signed [COEF_W-1:0] a2;
		logic                     bypass;
	} coef_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] x1;
		logic signed [SAMPLE_BITS-1:0] x2;
		logic signed [SAMPLE_BITS-1:0] y1;
		logic signed [SAMPLE_BITS-1:0] y2;
	} hist_t;

endpackage

// ===== design/sobq_ifs.sv =====
// Stream interfaces: input sample channel and filtered sample channel.
interface sobq_in_if;
	import sobq_pkg::*;
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;
	logic                          run_start;
	modport source (output valid, output sample_in, output run_start, input ready);
	modport sink   (input valid, input sample_in, input run_start, output ready);
endinterface

interface sobq_out_if;
	import sobq_pkg::*;
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic                          clipped;
	modport source (output valid, output sample_out, output clipped, input ready);
	modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

// ===== design/sobq_core.sv =====
// Biquad arithmetic: feedforward/feedback products, rounding, saturation, bypass.
module sobq_core (
	input  logic signed [sobq_pkg::SAMPLE_BITS-1:0] x,
	input  sobq_pkg::coef_t                         coef,
	input  sobq_pkg::hist_t                         hist,
	output logic signed [sobq_pkg::SAMPLE_BITS-1:0] y,
	output logic                                    clip
);
	import sobq_pkg::*;

	logic signed [XS_W-1:0]  xs;
	logic signed [PFF_W-1:0] p_ff;
	logic signed [PFB_W-1:0] p_a1;
	logic signed [PFB_W-1:0] p_a2;
	logic signed [ACC_W-1:0] acc;
	logic signed [SHR_W-1:0] shr;

	always_comb begin
		xs   = XS_W'(x) + (XS_W'(hist.x1) <<< 1) + XS_W'(hist.x2);
		p_ff = PFF_W'(coef.b0) * PFF_W'(xs);
		p_a1 = PFB_W'(coef.a1) * PFB_W'(hist.y1);
		p_a2 = PFB_W'(coef.a2) * PFB_W'(hist.y2);
		acc  = ACC_W'(p_ff) - ACC_W'(p_a1) - ACC_W'(p_a2) + ROUND_HALF;
		// arithmetic shift is floor division, so add-half then shift rounds half up
		shr  = acc[ACC_W-1:COEF_FRAC_BITS];
		y    = x;
		clip = 1'b0;
		if (!coef.bypass) begin
			if (shr > SHR_W'(SAMPLE_MAX)) begin
				y    = SAMPLE_MAX;
				clip = 1'b1;
			end else if (shr < SHR_W'(SAMPLE_MIN)) begin
				y    = SAMPLE_MIN;
				clip = 1'b1;
			end else begin
				y = shr[SAMPLE_BITS-1:0];
			end
		end
	end
endmodule

// ===== design/second_order_lowpass_biquad.sv =====
// Top level: second-order low-pass biquad, direct form I.
//
//  channel   dir   handshake      payload
//  s_in      in    valid/ready    sample_in[15:0] signed, run_start
//  m_out     out   valid/ready    sample_out[15:0] signed, clipped
//  wr_*      in    wr_en          wr_index[1:0], wr_data[19:0]
//
// Words register in x_s1, results in y_s2; one word per cycle unless m_out stalls.
// The input register feeds the combinational multiply/accumulate, whose result
// also updates the history, so the y(n-1) feedback loop sets the clock.
// arst_n clears history, coefficients (bypass set) and both valid flags.
// A stalled output holds its word; the input register takes one more word if empty.
module second_order_lowpass_biquad (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [sobq_pkg::REG_IDX_W-1:0]      wr_index,
	input  logic [sobq_pkg::COEF_W-1:0]         wr_data,
	sobq_in_if.sink                             s_in,
	sobq_out_if.source                          m_out
);
	import sobq_pkg::*;

	coef_t                         coef_q;
	hist_t                         hist_q;
	hist_t                         hist_use;
	logic                          valid_s1;
	logic signed [SAMPLE_BITS-1:0] x_s1;
	logic                          run_s1;
	logic                          valid_s2;
	logic signed [SAMPLE_BITS-1:0] y_s2;
	logic                          clip_s2;
	logic signed [SAMPLE_BITS-1:0] y_calc;
	logic                          clip_calc;
	logic                          adv_s1;

	assign adv_s1      = valid_s1 && (!valid_s2 || m_out.ready);
	assign s_in.ready  = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.b0     <= '0;
			coef_q.a1     <= '0;
			coef_q.a2     <= '0;
			coef_q.bypass <= 1'b1;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_GAIN_B0:     coef_q.b0     <= wr_data;
				REG_FEEDBACK_A1: coef_q.a1     <= wr_data;
				REG_FEEDBACK_A2: coef_q.a2     <= wr_data;
				REG_BYPASS_MODE: coef_q.bypass <= wr_data[0];
				default: ;
			endcase
		end
	end

	// run start clears history before this word is used
	always_comb begin
		hist_use = run_s1 ? '0 : hist_q;
	end

	sobq_core u_core (
		.x    (x_s1),
		.coef (coef_q),
		.hist (hist_use),
		.y    (y_calc),
		.clip (clip_calc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			hist_q   <= '0;
		end else begin
			if (s_in.ready) begin
				valid_s1 <= s_in.valid;
			end
			if (adv_s1) begin
				valid_s2  <= 1'b1;
				hist_q.x2 <= hist_use.x1;
				hist_q.x1 <= x_s1;
				hist_q.y2 <= hist_use.y1;
				hist_q.y1 <= y_calc;
			end else if (m_out.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_in.valid && s_in.ready) begin
			x_s1   <= s_in.sample_in;
			run_s1 <= s_in.run_start;
		end
		if (adv_s1) begin
			y_s2    <= y_calc;
			clip_s2 <= clip_calc;
		end
	end

	assign m_out.valid      = valid_s2;
	assign m_out.sample_out = y_s2;
	assign m_out.clipped    = clip_s2;

	a_clip_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && clip_s2) |-> (y_s2 == SAMPLE_MAX || y_s2 == SAMPLE_MIN))
		else $error("clipped word is not at a saturation bound");

	a_bypass_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && coef_q.bypass) |=> (y_s2 == $past(x_s1) && !clip_s2))
		else $error("bypass word altered");

	a_adv_valid: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> valid_s2)
		else $error("advanced word missing at output");

	a_run_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && run_s1) |=> (hist_q.x2 == '0 && hist_q.y2 == '0))
		else $error("run start did not clear history");

	a_hist_y1: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> (hist_q.y1 == y_s2))
		else $error("feedback history differs from delivered word");
endmodule

// ===== tb/biquad_output_checker.sv =====
`timescale 1ns / 100ps
// Biquad output checker: mirrors coefficient writes, predicts each filtered word, compares.
module biquad_output_checker
	import sobq_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [REG_IDX_W-1:0]          wr_index,
	input  logic [COEF_W-1:0]             wr_data,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] in_sample,
	input  logic                          in_run_start,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic signed [SAMPLE_BITS-1:0] out_sample,
	input  logic                          out_clipped,
	output int                            pending,
	output int                            errors,
	output int                            n_checked,
	output int                            n_clipped
);

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          clip;
	} filt_word_t;

	coef_t      coefs;
	hist_t      hist;
	filt_word_t filtered_due[$];

	task automatic report(input string what);
		$display("MISMATCH at %0t: %s", $time, what);
		errors++;
	endtask

	// one step of the direct form I filter, updates the mirrored history
	function automatic filt_word_t lowpass_next(input logic signed [SAMPLE_BITS-1:0] x,
	                                            input logic rs);
		longint     xs;
		longint     acc;
		longint     y;
		filt_word_t w;
		if (rs)
			hist = '0;
		w.clip = 1'b0;
		if (coefs.bypass) begin
			y = longint'(x);
		end else begin
			xs  = longint'(x) + 2 * longint'(hist.x1) + longint'(hist.x2);
			acc = longint'(coefs.b0) * xs
			    - longint'(coefs.a1) * longint'(hist.y1)
			    - longint'(coefs.a2) * longint'(hist.y2)
			    + (longint'(1) <<< (COEF_FRAC_BITS - 1));
			y = acc >>> COEF_FRAC_BITS;
			if (y > longint'(SAMPLE_MAX)) begin
				y      = longint'(SAMPLE_MAX);
				w.clip = 1'b1;
			end
			if (y < longint'(SAMPLE_MIN)) begin
				y      = longint'(SAMPLE_MIN);
				w.clip = 1'b1;
			end
		end
		w.sample = SAMPLE_BITS'(y);
		hist.x2  = hist.x1;
		hist.x1  = x;
		hist.y2  = hist.y1;
		hist.y1  = w.sample;
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		filt_word_t want;
		if (!arst_n) begin
			coefs.b0     = '0;
			coefs.a1     = '0;
			coefs.a2     = '0;
			coefs.bypass = 1'b1;
			hist         = '0;
			filtered_due.delete();
			pending      = 0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_GAIN_B0:     coefs.b0 = wr_data;
					REG_FEEDBACK_A1: coefs.a1 = wr_data;
					REG_FEEDBACK_A2: coefs.a2 = wr_data;
					REG_BYPASS_MODE: coefs.bypass = wr_data[0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (filtered_due.size() == 0) begin
					report($sformatf("output word %0d with nothing expected", out_sample));
				end else begin
					want = filtered_due.pop_front();
					if (out_sample !== want.sample)
						report($sformatf("word %0d: sample_out %0d, expected %0d",
						                 n_checked, out_sample, want.sample));
					if (out_clipped !== want.clip)
						report($sformatf("word %0d: clipped %b, expected %b",
						                 n_checked, out_clipped, want.clip));
					if (want.clip)
						n_clipped++;
				end
				n_checked++;
			end
			if (in_valid && in_ready)
				filtered_due.push_back(lowpass_next(in_sample, in_run_start));
			pending = filtered_due.size();
		end
	end

endmodule

// ===== tb/tb_second_order_lowpass_biquad.sv =====
`timescale 1ns / 100ps
// Testbench top: directed and random sample streams into the biquad, with the verdict.
module tb_second_order_lowpass_biquad;
	import sobq_pkg::*;

	localparam int     CYCLE_LIMIT = 200000;
	localparam int     RAND_PHASES = 8;
	localparam int     PHASE_WORDS = 50;
	localparam longint COEF_MAX    = (longint'(1) <<< (COEF_W - 1)) - 1;
	localparam longint COEF_MIN    = -(longint'(1) <<< (COEF_W - 1));
	// r = 0.8, cos = 0.9, unity gain at DC
	localparam longint LP_B0       = 3276;
	localparam longint LP_A1       = -94372;
	localparam longint LP_A2       = 41943;

	typedef enum int {COEF_LOWPASS, COEF_RANDOM, COEF_EXTREME, COEF_BYPASS} coef_mode_e;

	logic                 clk;
	logic                 arst_n;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] wr_index;
	logic [COEF_W-1:0]    wr_data;

	sobq_in_if  in_ch ();
	sobq_out_if out_ch ();

	int pending;
	int errors;
	int n_checked;
	int n_clipped;
	int cycles;
	int rx_hold;
	int n_sent;
	int n_settings;

	second_order_lowpass_biquad uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.s_in     (in_ch),
		.m_out    (out_ch)
	);

	biquad_output_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.in_valid     (in_ch.valid),
		.in_ready     (in_ch.ready),
		.in_sample    (in_ch.sample_in),
		.in_run_start (in_ch.run_start),
		.out_valid    (out_ch.valid),
		.out_ready    (out_ch.ready),
		.out_sample   (out_ch.sample_out),
		.out_clipped  (out_ch.clipped),
		.pending      (pending),
		.errors       (errors),
		.n_checked    (n_checked),
		.n_clipped    (n_clipped)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// cycle limit and receiver stalls; a new stall starts only while cycles[8] is set
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Some tests failed");
			$finish;
		end
		if (rx_hold != 0) begin
			out_ch.ready <= 1'b0;
			rx_hold      <= rx_hold - 1;
		end else begin
			out_ch.ready <= 1'b1;
			if (cycles[8] && $urandom_range(0, 3) == 0)
				rx_hold <= $urandom_range(1, 7);
		end
	end

	function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
		case ($urandom_range(0, 9))
			0:          return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
			1, 2, 3, 4: return SAMPLE_BITS'($urandom);
			default:    return SAMPLE_BITS'(int'($urandom_range(0, 4095)) - 2048);
		endcase
	endfunction

	// called on a clock edge; returns on the edge where the word is taken
	task automatic push_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic rs);
		in_ch.valid     <= 1'b1;
		in_ch.sample_in <= s;
		in_ch.run_start <= rs;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		n_sent++;
	endtask

	task automatic pause_in(input int n);
		in_ch.valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain_out();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic set_coefs(input longint b0, input longint a1, input longint a2,
	                         input logic byp);
		drain_out();
		wr_en    <= 1'b1;
		wr_index <= REG_GAIN_B0;
		wr_data  <= COEF_W'(b0);
		@(posedge clk);
		wr_index <= REG_FEEDBACK_A1;
		wr_data  <= COEF_W'(a1);
		@(posedge clk);
		wr_index <= REG_FEEDBACK_A2;
		wr_data  <= COEF_W'(a2);
		@(posedge clk);
		// upper bits of the bypass word are junk on purpose
		wr_index <= REG_BYPASS_MODE;
		wr_data  <= {(COEF_W - 1)'($urandom), byp};
		@(posedge clk);
		wr_en <= 1'b0;
		@(posedge clk);
		n_settings++;
	endtask

	task automatic pick_coefs(input coef_mode_e mode);
		longint r;
		longint c;
		longint b0;
		longint a1;
		longint a2;
		b0 = 0;
		a1 = 0;
		a2 = 0;
		case (mode)
			COEF_LOWPASS, COEF_BYPASS: begin
				// pole radius r and cos(theta), both Q16
				r  = $urandom_range(40000, 64500);
				c  = $urandom_range(30000, 65000);
				a2 = (r * r) >>> 16;
				a1 = -((2 * r * c) >>> 16);
				b0 = (65536 + a1 + a2) >>> 2;
				if (b0 < 1)
					b0 = 1;
			end
			COEF_RANDOM: begin
				b0 = $urandom;
				a1 = $urandom;
				a2 = $urandom;
			end
			COEF_EXTREME: begin
				b0 = $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
				a1 = $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
				a2 = $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
			end
			default: ;
		endcase
		set_coefs(b0, a1, a2, mode == COEF_BYPASS);
	endtask

	// runs open with a start word; an odd stray start breaks a run up
	task automatic run_phase(input int n_words);
		int   left;
		int   burst;
		int   run_len;
		logic rs;
		left    = n_words;
		run_len = 0;
		while (left > 0) begin
			burst = $urandom_range(1, 12);
			while (burst > 0 && left > 0) begin
				if (run_len == 0) begin
					rs      = 1'b1;
					run_len = $urandom_range(4, 40);
				end else begin
					rs = ($urandom_range(0, 49) == 0);
				end
				push_sample(rand_sample(), rs);
				run_len--;
				burst--;
				left--;
				if (left == n_words / 2)
					drain_out();
			end
			if ($urandom_range(0, 2) != 0)
				pause_in($urandom_range(1, 6));
		end
	endtask

	initial begin
		int p;
		arst_n          = 1'b0;
		wr_en           = 1'b0;
		wr_index        = '0;
		wr_data         = '0;
		in_ch.valid     = 1'b0;
		in_ch.sample_in = '0;
		in_ch.run_start = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// out of reset the block is in bypass
		push_sample(SAMPLE_MAX, 1'b0);
		push_sample(SAMPLE_MIN, 1'b0);
		push_sample(16'sd0, 1'b0);
		push_sample(-16'sd1, 1'b1);

		// b0 = 0.25, no feedback: impulse shows the 1-2-1 taps
		set_coefs(16384, 0, 0, 1'b0);
		push_sample(SAMPLE_MAX, 1'b1);
		push_sample(16'sd0, 1'b0);
		push_sample(16'sd0, 1'b0);
		push_sample(16'sd0, 1'b0);
		push_sample(SAMPLE_MIN, 1'b0);

		// largest gain: saturation both ways, rounding of a tiny input
		set_coefs(COEF_MAX, 0, 0, 1'b0);
		push_sample(SAMPLE_MAX, 1'b1);
		push_sample(SAMPLE_MIN, 1'b1);
		push_sample(16'sd1, 1'b1);

		// most negative coefficients everywhere
		set_coefs(COEF_MIN, COEF_MIN, COEF_MIN, 1'b0);
		push_sample(SAMPLE_MAX, 1'b1);
		push_sample(SAMPLE_MAX, 1'b0);
		push_sample(SAMPLE_MIN, 1'b0);

		// history keeps shifting in bypass, so the filter picks up where bypass left it
		set_coefs(LP_B0, LP_A1, LP_A2, 1'b1);
		push_sample(16'sd1000, 1'b0);
		push_sample(16'sd2000, 1'b0);
		set_coefs(LP_B0, LP_A1, LP_A2, 1'b0);
		push_sample(16'sd3000, 1'b0);
		push_sample(16'sd4000, 1'b0);
		// start word in bypass still clears the history
		set_coefs(LP_B0, LP_A1, LP_A2, 1'b1);
		push_sample(16'sd5, 1'b1);
		set_coefs(LP_B0, LP_A1, LP_A2, 1'b0);
		push_sample(16'sd6, 1'b0);

		for (p = 0; p < RAND_PHASES; p++) begin
			pick_coefs(coef_mode_e'(p % 4));
			run_phase(PHASE_WORDS);
		end

		drain_out();
		repeat (8) @(posedge clk);
		$display("Ran %0d input words through %0d coefficient settings", n_sent, n_settings);
		$display("(bypass, low-pass, random and extreme); %0d results checked, %0d clipped",
		         n_checked, n_clipped);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/sobq_pkg.sv
design/sobq_ifs.sv
design/sobq_core.sv
design/second_order_lowpass_biquad.sv
tb/biquad_output_checker.sv
tb/tb_second_order_lowpass_biquad.sv
